FILE: design/srec_pkg.sv
// Shared types, constants and character helpers for the S-record encoder.
`timescale 1ns / 1ps
`default_nettype none

package srec_pkg;

  localparam int unsigned RECORD_BYTES = 32;
  localparam int unsigned CharW        = 7;
  localparam int unsigned TailItems    = 6;

  localparam logic [CharW-1:0] CHAR_S  = 7'h53;
  localparam logic [CharW-1:0] CHAR_1  = 7'h31;
  localparam logic [CharW-1:0] CHAR_LF = 7'h0A;

  localparam logic [CharW-1:0] HEX_DIGITS [16] = '{
    7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
    7'h38, 7'h39, 7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46
  };

  // Field of the output item being produced
  typedef enum logic [2:0] {
    SEL_HEAD,
    SEL_COUNT,
    SEL_ADDR_HI,
    SEL_ADDR_LO,
    SEL_DATA,
    SEL_CSUM,
    SEL_NEWLINE,
    SEL_TAIL
  } sel_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HEAD,
    ST_COUNT,
    ST_ADDR_HI,
    ST_ADDR_LO,
    ST_DATA,
    ST_CSUM,
    ST_NEWLINE,
    ST_TAIL
  } state_e;

  typedef struct packed {
    logic       take;     // input channel ready
    logic       emit;     // load the output register
    sel_e       sel;
    logic       last;     // final item of this input
    logic       rec_end;  // record complete, update address and fill
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic flush_now;  // byte on the input closes a record
    logic out_free;   // output register can take an item
    logic fill_zero;
    logic data_last;
    logic full_rec;
    logic eof_pend;
    logic eot_pend;
    logic tail_last;
  } ctrl_status_t;

  typedef struct packed {
    logic [CharW-1:0] c1;
    logic [CharW-1:0] c2;
    logic [1:0]       cnt;
  } item_t;

  function automatic logic [CharW-1:0] hex_char(input logic [3:0] nib);
    return HEX_DIGITS[nib];
  endfunction

  function automatic item_t hex_pair(input logic [7:0] val);
    item_t it;
    it.c1  = hex_char(val[7:4]);
    it.c2  = hex_char(val[3:0]);
    it.cnt = 2'd2;
    return it;
  endfunction

  // Fixed end record "S9030000FC\n" as character pairs
  function automatic item_t tail_pair(input logic [2:0] idx);
    item_t it;
    unique case (idx)
      3'd0:    it = '{c1: CHAR_S, c2: 7'h39, cnt: 2'd2};
      3'd1:    it = '{c1: 7'h30, c2: 7'h33, cnt: 2'd2};
      3'd2:    it = '{c1: 7'h30, c2: 7'h30, cnt: 2'd2};
      3'd3:    it = '{c1: 7'h30, c2: 7'h30, cnt: 2'd2};
      3'd4:    it = '{c1: 7'h46, c2: 7'h43, cnt: 2'd2};
      3'd5:    it = '{c1: CHAR_LF, c2: 7'h00, cnt: 2'd1};
      default: it = '{c1: CHAR_LF, c2: 7'h00, cnt: 2'd1};
    endcase
    return it;
  endfunction

endpackage

`default_nettype wire

FILE: design/srec_byte_if.sv
// Input channel: one raw byte with file and transfer end flags.
`timescale 1ns / 1ps
`default_nettype none

interface srec_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_file;
  logic       end_of_transfer;

  modport source (output valid, data_byte, end_of_file, end_of_transfer, input ready);
  modport sink   (input valid, data_byte, end_of_file, end_of_transfer, output ready);
endinterface

`default_nettype wire

FILE: design/srec_char_if.sv
// Output channel: one or two ASCII characters per transfer.
`timescale 1ns / 1ps
`default_nettype none

interface srec_char_if;
  logic       valid;
  logic       ready;
  logic [6:0] char_first;
  logic [6:0] char_second;
  logic [1:0] char_count;
  logic       last_of_run;

  modport source (output valid, char_first, char_second, char_count, last_of_run,
                  input ready);
  modport sink   (input valid, char_first, char_second, char_count, last_of_run,
                  output ready);
endinterface

`default_nettype wire

FILE: design/srec_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module srec_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                                        clk_i,
  input  logic                                        wr_en_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] wr_addr_i,
  input  logic [Width-1:0]                            wr_data_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] rd_addr_i,
  output logic [Width-1:0]                            rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

FILE: design/srec_ctrl.sv
// Record sequencer: walks the fields of each record and the end record.
`timescale 1ns / 1ps
`default_nettype none

module srec_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  srec_pkg::ctrl_status_t status_i,
  output srec_pkg::ctrl_cmd_t    cmd_o
);
  import srec_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (status_i.in_valid && status_i.flush_now) state_d = ST_HEAD;
      end
      ST_HEAD:    if (status_i.out_free) state_d = ST_COUNT;
      ST_COUNT:   if (status_i.out_free) state_d = ST_ADDR_HI;
      ST_ADDR_HI: if (status_i.out_free) state_d = ST_ADDR_LO;
      ST_ADDR_LO: begin
        if (status_i.out_free) state_d = status_i.fill_zero ? ST_CSUM : ST_DATA;
      end
      ST_DATA: begin
        if (status_i.out_free && status_i.data_last) state_d = ST_CSUM;
      end
      ST_CSUM:    if (status_i.out_free) state_d = ST_NEWLINE;
      ST_NEWLINE: begin
        if (status_i.out_free) begin
          priority if (status_i.full_rec && status_i.eof_pend) state_d = ST_HEAD;
          else if (!status_i.full_rec && status_i.eot_pend)    state_d = ST_TAIL;
          else                                                  state_d = ST_IDLE;
        end
      end
      ST_TAIL: begin
        if (status_i.out_free && status_i.tail_last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '{take: 1'b0, emit: 1'b0, sel: SEL_HEAD, last: 1'b0, rec_end: 1'b0};
    unique case (state_q)
      ST_IDLE:    cmd_o.take = 1'b1;
      ST_HEAD:    begin cmd_o.emit = status_i.out_free; cmd_o.sel = SEL_HEAD;    end
      ST_COUNT:   begin cmd_o.emit = status_i.out_free; cmd_o.sel = SEL_COUNT;   end
      ST_ADDR_HI: begin cmd_o.emit = status_i.out_free; cmd_o.sel = SEL_ADDR_HI; end
      ST_ADDR_LO: begin cmd_o.emit = status_i.out_free; cmd_o.sel = SEL_ADDR_LO; end
      ST_DATA:    begin cmd_o.emit = status_i.out_free; cmd_o.sel = SEL_DATA;    end
      ST_CSUM:    begin cmd_o.emit = status_i.out_free; cmd_o.sel = SEL_CSUM;    end
      ST_NEWLINE: begin
        cmd_o.emit    = status_i.out_free;
        cmd_o.sel     = SEL_NEWLINE;
        cmd_o.rec_end = status_i.out_free;
        cmd_o.last    = status_i.full_rec ? !status_i.eof_pend : !status_i.eot_pend;
      end
      ST_TAIL: begin
        cmd_o.emit = status_i.out_free;
        cmd_o.sel  = SEL_TAIL;
        cmd_o.last = status_i.tail_last;
      end
      default: cmd_o.take = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

FILE: design/srec_dpath.sv
// Datapath: byte buffer, fill, address and sum registers, field encoder, output register.
`timescale 1ns / 1ps
`default_nettype none

module srec_dpath #(
  parameter int unsigned RecordBytes = srec_pkg::RECORD_BYTES
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  srec_pkg::ctrl_cmd_t    cmd_i,
  output srec_pkg::ctrl_status_t status_o,
  srec_byte_if.sink              in_chan_i,
  srec_char_if.source            out_chan_o
);
  import srec_pkg::*;

  localparam int unsigned IdxW = (RecordBytes > 1) ? $clog2(RecordBytes) : 1;
  localparam int unsigned CntW = $clog2(RecordBytes + 1);

  logic [CntW-1:0] fill_q, fill_d;
  logic [15:0]     addr_q, addr_d;
  logic [7:0]      sum_q, sum_d;
  logic            eof_q, eof_d;
  logic            eot_q, eot_d;
  logic [IdxW-1:0] rd_idx_q, rd_idx_d;
  logic [2:0]      tail_idx_q, tail_idx_d;
  logic            out_valid_q;
  item_t           out_item_q;
  logic            out_last_q;

  logic            accept;
  logic            out_free;
  logic            full_rec;
  logic [7:0]      rec_count;
  logic [7:0]      csum;
  logic [7:0]      rd_data;
  item_t           item;

  assign accept   = cmd_i.take && in_chan_i.valid;
  assign out_free = !out_valid_q || out_chan_o.ready;
  assign full_rec = (fill_q == CntW'(RecordBytes));

  assign rec_count = 8'(fill_q) + 8'd3;
  assign csum      = ~(rec_count + addr_q[15:8] + addr_q[7:0] + sum_q);

  srec_ram #(
    .Width (8),
    .Depth (RecordBytes)
  ) u_buf (
    .clk_i     (clk_i),
    .wr_en_i   (accept),
    .wr_addr_i (fill_q[IdxW-1:0]),
    .wr_data_i (in_chan_i.data_byte),
    .rd_addr_i (rd_idx_d),
    .rd_data_o (rd_data)
  );

  always_comb begin
    status_o.in_valid  = in_chan_i.valid;
    status_o.flush_now = (fill_q + CntW'(1) == CntW'(RecordBytes)) ||
                         in_chan_i.end_of_file || in_chan_i.end_of_transfer;
    status_o.out_free  = out_free;
    status_o.fill_zero = (fill_q == '0);
    status_o.data_last = (CntW'(rd_idx_q) + CntW'(1) == fill_q);
    status_o.full_rec  = full_rec;
    status_o.eof_pend  = eof_q;
    status_o.eot_pend  = eot_q;
    status_o.tail_last = (tail_idx_q == 3'(TailItems - 1));
  end

  // Field encoder
  always_comb begin
    unique case (cmd_i.sel)
      SEL_HEAD:    item = '{c1: CHAR_S, c2: CHAR_1, cnt: 2'd2};
      SEL_COUNT:   item = hex_pair(rec_count);
      SEL_ADDR_HI: item = hex_pair(addr_q[15:8]);
      SEL_ADDR_LO: item = hex_pair(addr_q[7:0]);
      SEL_DATA:    item = hex_pair(rd_data);
      SEL_CSUM:    item = hex_pair(csum);
      SEL_NEWLINE: item = '{c1: CHAR_LF, c2: 7'h00, cnt: 2'd1};
      SEL_TAIL:    item = tail_pair(tail_idx_q);
      default:     item = '{c1: CHAR_LF, c2: 7'h00, cnt: 2'd1};
    endcase
  end

  always_comb begin
    fill_d     = fill_q;
    addr_d     = addr_q;
    sum_d      = sum_q;
    eof_d      = eof_q;
    eot_d      = eot_q;
    rd_idx_d   = rd_idx_q;
    tail_idx_d = tail_idx_q;
    if (accept) begin
      fill_d = fill_q + CntW'(1);
      sum_d  = sum_q + in_chan_i.data_byte;
      eof_d  = in_chan_i.end_of_file || in_chan_i.end_of_transfer;
      eot_d  = in_chan_i.end_of_transfer;
    end
    if (cmd_i.emit && cmd_i.sel == SEL_HEAD) rd_idx_d = '0;
    if (cmd_i.emit && cmd_i.sel == SEL_DATA) rd_idx_d = rd_idx_q + IdxW'(1);
    if (cmd_i.rec_end) begin
      fill_d = '0;
      sum_d  = '0;
      if (full_rec) begin
        addr_d = addr_q + 16'(RecordBytes);
      end else begin
        addr_d = '0;
        eof_d  = 1'b0;
      end
    end
    if (cmd_i.emit && cmd_i.sel == SEL_TAIL) begin
      if (status_o.tail_last) begin
        tail_idx_d = '0;
        eot_d      = 1'b0;
      end else begin
        tail_idx_d = tail_idx_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      addr_q      <= '0;
      sum_q       <= '0;
      eof_q       <= 1'b0;
      eot_q       <= 1'b0;
      rd_idx_q    <= '0;
      tail_idx_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      fill_q     <= fill_d;
      addr_q     <= addr_d;
      sum_q      <= sum_d;
      eof_q      <= eof_d;
      eot_q      <= eot_d;
      rd_idx_q   <= rd_idx_d;
      tail_idx_q <= tail_idx_d;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_chan_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_item_q <= item;
      out_last_q <= cmd_i.last;
    end
  end

  assign in_chan_i.ready        = cmd_i.take;
  assign out_chan_o.valid       = out_valid_q;
  assign out_chan_o.char_first  = out_item_q.c1;
  assign out_chan_o.char_second = out_item_q.c2;
  assign out_chan_o.char_count  = out_item_q.cnt;
  assign out_chan_o.last_of_run = out_last_q;

endmodule

`default_nettype wire

FILE: design/srecord_s1_encoder.sv
// Top level of the Motorola S1 record encoder.
// After the closing byte, the sequencer enters its head state and loads the first pair into
// the output register when free. A byte that closes no record is taken while idle; a record
// of n bytes holds the input for n + 6 transfers, plus 6 for the S9 record, one per cycle unless
// the output stalls. The rate is set by the single field sequencer and the one-port buffer read.
// Reset (rst_ni low, asynchronous) clears fill, address, sum and sequencer; buffer is not reset.
`timescale 1ns / 1ps
`default_nettype none

module srecord_s1_encoder #(
  parameter int unsigned RecordBytes = srec_pkg::RECORD_BYTES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  srec_byte_if.sink   in_chan_i,
  srec_char_if.source out_chan_o
);
  import srec_pkg::*;

  // Command and status between sequencer and datapath
  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  // Sequencer: holds the input while a record or the end record is streamed,
  // advancing through the fields as the output register takes their items.
  srec_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cmd_o    (cmd)
  );

  // Datapath: buffers bytes, keeps address and running sum, encodes each field as hex
  // and drives the output register, which holds each item until taken while the sequencer waits.
  srec_dpath #(
    .RecordBytes (RecordBytes)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .in_chan_i  (in_chan_i),
    .out_chan_o (out_chan_o)
  );

endmodule

`default_nettype wire

FILE: tb/srecord_s1_encoder_tb.sv
// S1 encoder testbench: directed and random byte streams checked against a predicted stream.
`timescale 1ns / 1ps

module srecord_s1_encoder_tb;
  import srec_pkg::*;

  // Printable hex digits start at these offsets from the nibble value
  localparam logic [6:0] ASCII_DIGIT_BASE  = 7'h30;
  localparam logic [6:0] ASCII_LETTER_BASE = 7'h37;
  // Fixed record that closes a transfer, first character in the top byte
  localparam logic [87:0] END_RECORD     = "S9030000FC\n";
  localparam int          END_RECORD_LEN = 11;
  localparam int          DIRECTED_LEN   = 9;
  localparam int          RANDOM_ITEMS   = 360;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_LIGHT,
    IDLE_HEAVY
  } idle_mode_e;

  typedef enum logic [1:0] {
    FILL_RANDOM,
    FILL_ONES,
    FILL_ZEROS
  } fill_e;

  // One raw byte waiting to go out, with its pacing hints
  typedef struct {
    logic [7:0] value;
    logic       eof;
    logic       eot;
    logic       drain;      // hold this byte until every pending pair has arrived
    idle_mode_e idle_mode;
  } raw_byte_t;

  // One character-pair transfer as the encoder should produce it
  typedef struct {
    logic [6:0] c1;
    logic [6:0] c2;
    logic [1:0] cnt;
    logic       last;
  } char_pair_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  srec_byte_if in_bus ();
  srec_char_if out_bus ();

  srecord_s1_encoder DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_chan_i  (in_bus),
    .out_chan_o (out_bus)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  raw_byte_t  bytes_to_send [$];
  char_pair_t pairs_due [$];
  int         mismatches = 0;

  // Encoder state as the predictor tracks it
  logic [7:0]  rec_buf [RECORD_BYTES];
  logic [5:0]  rec_fill;
  logic [15:0] rec_addr;
  logic [7:0]  rec_sum;

  // Characters of the line being built, and the pair held back until we know
  // whether it closes the run of this input byte
  logic [6:0]  line_chars [80];
  int          line_len;
  char_pair_t  held_pair;
  logic        have_held;

  idle_mode_e  pace_mode = IDLE_NONE;
  int          gap_left;
  int          stall_left;
  char_pair_t  due_pair;

  function automatic logic [6:0] nib_to_ascii(input logic [3:0] nib);
    return (nib < 4'd10) ? ASCII_DIGIT_BASE + nib : ASCII_LETTER_BASE + nib;
  endfunction

  function automatic bit burst_starts(input idle_mode_e mode);
    case (mode)
      IDLE_LIGHT: return $urandom_range(0, 7) == 0;
      IDLE_HEAVY: return $urandom_range(0, 2) == 0;
      default:    return 1'b0;
    endcase
  endfunction

  task automatic add_char(input logic [6:0] c);
    line_chars[line_len] = c;
    line_len++;
  endtask

  task automatic add_hex(input logic [7:0] v);
    add_char(nib_to_ascii(v[7:4]));
    add_char(nib_to_ascii(v[3:0]));
  endtask

  // Queue the previously held pair as a non-final one and hold the new pair
  task automatic hold_pair(input logic [6:0] c1, input logic [6:0] c2, input logic [1:0] cnt);
    if (have_held) pairs_due.push_back(held_pair);
    held_pair = '{c1: c1, c2: c2, cnt: cnt, last: 1'b0};
    have_held = 1'b1;
  endtask

  // Split the built line into two-character transfers, an odd tail as one
  task automatic split_line();
    int i;
    for (i = 0; i < line_len; i += 2) begin
      if (i + 1 < line_len) hold_pair(line_chars[i], line_chars[i + 1], 2'd2);
      else hold_pair(line_chars[i], 7'h00, 2'd1);
    end
    line_len = 0;
  endtask

  // Build one S1 line from the buffered bytes at the current address
  task automatic build_s1_line();
    logic [7:0] count_byte;
    logic [7:0] csum;
    int         i;
    count_byte = {2'b00, rec_fill} + 8'd3;
    csum = ~(count_byte + rec_addr[15:8] + rec_addr[7:0] + rec_sum);
    add_char(CHAR_S);
    add_char(CHAR_1);
    add_hex(count_byte);
    add_hex(rec_addr[15:8]);
    add_hex(rec_addr[7:0]);
    for (i = 0; i < rec_fill; i++) add_hex(rec_buf[i]);
    add_hex(csum);
    add_char(CHAR_LF);
    split_line();
  endtask

  // Work out every transfer that one accepted input byte causes
  task automatic srec_encode_byte(input logic [7:0] value, input logic eof_in,
                                  input logic eot_in);
    logic file_ends;
    int   i;
    file_ends = eof_in | eot_in;   // a transfer end always closes the file too
    rec_buf[rec_fill[4:0]] = value;
    rec_fill = rec_fill + 6'd1;
    rec_sum  = rec_sum + value;
    if (rec_fill >= RECORD_BYTES) begin
      build_s1_line();
      rec_addr = rec_addr + 16'(RECORD_BYTES);
      rec_fill = '0;
      rec_sum  = '0;
    end
    // A file ending right on a record boundary still gets its own empty record
    if (file_ends) begin
      build_s1_line();
      rec_addr = '0;
      rec_fill = '0;
      rec_sum  = '0;
    end
    if (eot_in) begin
      for (i = 0; i < END_RECORD_LEN; i++)
        add_char(END_RECORD[8 * (END_RECORD_LEN - 1 - i) +: 7]);
      split_line();
    end
    // Mark the final transfer of this byte's run
    if (have_held) begin
      held_pair.last = 1'b1;
      pairs_due.push_back(held_pair);
      have_held = 1'b0;
    end
  endtask

  task automatic queue_byte(input logic [7:0] value, input logic eof, input logic eot,
                            input logic drain, input idle_mode_e mode);
    raw_byte_t rb;
    rb = '{value: value, eof: eof, eot: eot, drain: drain, idle_mode: mode};
    bytes_to_send.push_back(rb);
  endtask

  task automatic queue_file(input int len, input logic eof_end, input logic eot_end,
                            input idle_mode_e mode, input logic drain_first, input fill_e kind);
    logic [7:0] value;
    int         i;
    for (i = 0; i < len; i++) begin
      case (kind)
        FILL_ONES:  value = 8'hFF;
        FILL_ZEROS: value = 8'h00;
        default:    value = 8'($urandom_range(0, 255));
      endcase
      queue_byte(value, (i == len - 1) ? eof_end : 1'b0, (i == len - 1) ? eot_end : 1'b0,
                 (i == 0) ? drain_first : 1'b0, mode);
    end
  endtask

  // Favor lengths around the record boundary, with exact multiples now and then
  function automatic int pick_file_len();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 2) return 1;
    if (pick < 5) return RECORD_BYTES * $urandom_range(1, 2);
    if (pick < 7) return ($urandom_range(0, 1) == 1) ? RECORD_BYTES - 1 : RECORD_BYTES + 1;
    if (pick < 15) return $urandom_range(2, RECORD_BYTES - 1);
    return $urandom_range(RECORD_BYTES + 2, 90);
  endfunction

  // Byte sender: predict on each transfer, then present the next byte unless pausing
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_bus.valid           <= 1'b0;
      in_bus.data_byte       <= '0;
      in_bus.end_of_file     <= 1'b0;
      in_bus.end_of_transfer <= 1'b0;
      gap_left               <= 0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        srec_encode_byte(bytes_to_send[0].value, bytes_to_send[0].eof, bytes_to_send[0].eot);
        void'(bytes_to_send.pop_front());
      end
      // Hold the byte steady while the encoder is not taking it
      if (!(in_bus.valid && !in_bus.ready)) begin
        if (gap_left > 0) begin
          gap_left     <= gap_left - 1;
          in_bus.valid <= 1'b0;
        end else if (bytes_to_send.size() > 0 &&
                     (!bytes_to_send[0].drain || pairs_due.size() == 0)) begin
          in_bus.valid           <= 1'b1;
          in_bus.data_byte       <= bytes_to_send[0].value;
          in_bus.end_of_file     <= bytes_to_send[0].eof;
          in_bus.end_of_transfer <= bytes_to_send[0].eot;
          pace_mode = bytes_to_send[0].idle_mode;
          if (burst_starts(pace_mode)) gap_left <= $urandom_range(1, 7);
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Character receiver: compare each transfer with the oldest prediction, stall in bursts
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
      stall_left    <= 0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (pairs_due.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected transfer, expected none, ", $time,
                   "got first=%h second=%h count=%0d last=%0b",
                   out_bus.char_first, out_bus.char_second, out_bus.char_count,
                   out_bus.last_of_run);
        end else begin
          due_pair = pairs_due[0];
          void'(pairs_due.pop_front());
          // The second character only counts when two are carried
          if (out_bus.char_first !== due_pair.c1 || out_bus.char_count !== due_pair.cnt ||
              (due_pair.cnt == 2'd2 && out_bus.char_second !== due_pair.c2) ||
              out_bus.last_of_run !== due_pair.last) begin
            mismatches++;
            $display("%0t: mismatch, expected first=%h second=%h count=%0d last=%0b, ",
                     $time, due_pair.c1, due_pair.c2, due_pair.cnt, due_pair.last,
                     "got first=%h second=%h count=%0d last=%0b",
                     out_bus.char_first, out_bus.char_second, out_bus.char_count,
                     out_bus.last_of_run);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left    <= stall_left - 1;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
        if (burst_starts(pace_mode)) stall_left <= $urandom_range(1, 7);
      end
    end
  end

  initial begin
    int         nfiles;
    int         f;
    idle_mode_e mode;
    fill_e      kind;

    rst_ni    = 1'b0;
    rec_fill  = '0;
    rec_addr  = '0;
    rec_sum   = '0;
    line_len  = 0;
    have_held = 1'b0;

    // Directed: extreme bytes in one-byte files, transfer end with and without file end
    queue_byte(8'h00, 1'b1, 1'b0, 1'b0, IDLE_NONE);
    queue_byte(8'hFF, 1'b1, 1'b0, 1'b0, IDLE_NONE);
    queue_byte(8'h12, 1'b0, 1'b0, 1'b1, IDLE_LIGHT);
    queue_byte(8'h34, 1'b0, 1'b0, 1'b0, IDLE_LIGHT);
    queue_byte(8'hAB, 1'b0, 1'b1, 1'b0, IDLE_LIGHT);
    queue_byte(8'h80, 1'b1, 1'b1, 1'b1, IDLE_HEAVY);
    queue_byte(8'h7F, 1'b0, 1'b0, 1'b0, IDLE_HEAVY);
    queue_byte(8'h01, 1'b1, 1'b0, 1'b0, IDLE_HEAVY);
    queue_byte(8'h55, 1'b1, 1'b1, 1'b0, IDLE_NONE);

    // Random transfers of one to three files each; the closing byte of the last file
    // may carry the transfer end alone
    while (bytes_to_send.size() < DIRECTED_LEN + RANDOM_ITEMS) begin
      nfiles = $urandom_range(1, 3);
      mode   = idle_mode_e'($urandom_range(0, 2));
      for (f = 0; f < nfiles; f++) begin
        kind = ($urandom_range(0, 9) == 0) ? FILL_ONES :
               ($urandom_range(0, 9) == 0) ? FILL_ZEROS : FILL_RANDOM;
        queue_file(pick_file_len(),
                   (f == nfiles - 1) ? ($urandom_range(0, 3) != 0) : 1'b1,
                   (f == nfiles - 1), mode, ($urandom_range(0, 3) == 0), kind);
      end
    end

    // Closing transfer without idling: a full record, a partial one and the end record
    queue_file(RECORD_BYTES + 7, 1'b1, 1'b1, IDLE_NONE, 1'b1, FILL_RANDOM);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (bytes_to_send.size() != 0 || pairs_due.size() != 0) @(posedge clk_i);
    // Let any stray transfer show up before judging
    repeat (60) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[srecord_s1_encoder] OK");
    end else begin
      $display("[srecord_s1_encoder] ERROR");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("[srecord_s1_encoder] ERROR");
    $finish;
  end

endmodule
